// ===== hdl/nested_spec_link_scanner_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the scanner RTL.
// ----------------------------------------------------------------------------
`ifndef NESTED_SPEC_LINK_SCANNER_UNIT_ASSERT_SVH
`define NESTED_SPEC_LINK_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define NSLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scanner assertion failed");

// Next-cycle implication, masked during reset.
`define NSLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scanner assertion failed");

`endif

// ===== hdl/nsls_pkg.sv =====
// ----------------------------------------------------------------------------
// nsls_pkg
// Types, character codes and defaults for the spec link scanner.
// ----------------------------------------------------------------------------
package nsls_pkg;

    localparam int STACK_DEPTH_DEF = 4;
    localparam int MAX_LEN_DEF     = 65536;

    localparam logic [7:0] CH_D      = 8'h44;  // 'D'
    localparam logic [7:0] CH_L      = 8'h4C;  // 'L'
    localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
    localparam logic [7:0] CH_OPEN   = 8'h28;  // '('
    localparam logic [7:0] CH_CLOSE  = 8'h29;  // ')'
    localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
    localparam logic [7:0] CH_QUOTE  = 8'h22;  // '"'

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_OVERFLOW  = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_QUOTE     = 3'd3,
        ERR_TOO_LONG  = 3'd4
    } t_err;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [15:0] link_from;
        logic [15:0] link_to;
        logic        is_summary;
        logic [15:0] container_total;
        t_err        error_code;
        logic        end_of_run;
    } t_out;

endpackage

// ===== hdl/nested_spec_link_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// nested_spec_link_scanner_unit
// Streaming scanner for nested structure-spec strings that emits link writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel carries one character per transaction (ch, last). Output
//   channel carries result transactions: link writes, error reports and one
//   end summary after the character flagged last.
//   Each character is processed in the cycle it is accepted; its results
//   (zero to three) are registered in the result buffer and leave it one
//   per cycle while the output is not stalled. Throughput: one character per
//   cycle while each character yields at most one result and the output is
//   not stalled; a character yielding more results stalls the input while
//   the single output register drains the result buffer.
//   The group stack keeps its top in a register and the rest in a small
//   memory with a registered read of the entry below the top.
//   Reset (synchronous, active low) clears position, quote flag, stack count,
//   container count and the result buffer; stack memory is not cleared.
//   A stalled output holds its transaction; the input is stalled while more
//   than one result is pending, while one is pending and the output stalls,
//   and throughout reset.
// ----------------------------------------------------------------------------
module nested_spec_link_scanner_unit #(
    parameter int STACK_DEPTH = nsls_pkg::STACK_DEPTH_DEF,
    parameter int MAX_LEN     = nsls_pkg::MAX_LEN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  nsls_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output nsls_pkg::t_out o_out_data
);
    import nsls_pkg::*;

    `include "nested_spec_link_scanner_unit_assert.svh"

    localparam int POS_W = $clog2(MAX_LEN + 1);  // position can reach MAX_LEN
    localparam int IDX_W = $clog2(MAX_LEN);      // positions of processed chars
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int MEM_D = (STACK_DEPTH > 1) ? STACK_DEPTH - 1 : 1;
    localparam int MA_W  = (MEM_D > 1) ? $clog2(MEM_D) : 1;

    // Scanner state
    logic [POS_W-1:0] r_pos,      n_pos;
    logic             r_in_quote, n_in_quote;
    logic [IDX_W-1:0] r_qstart,   n_qstart;
    logic [IDX_W-1:0] r_top,      n_top;
    logic [CNT_W-1:0] r_count,    n_count;
    logic [15:0]      r_cont,     n_cont;
    logic [IDX_W-1:0] r_below;

    // Entries below the top of the group stack
    logic [IDX_W-1:0] r_stack_mem [MEM_D];

    // Result buffer: slot 0 drives the output
    t_out             r_res [3];
    logic [1:0]       r_res_cnt;

    logic             in_acc;
    logic             out_acc;
    logic [IDX_W-1:0] p;
    t_out             proc0, proc1, summ;
    t_out             slot [3];
    logic [1:0]       proc_cnt;
    logic [1:0]       n_res;
    logic             mem_we;
    logic [MA_W-1:0]  mem_wa;
    logic [IDX_W-1:0] mem_wd;
    logic [CNT_W-1:0] eff_count;
    logic [MA_W-1:0]  mem_ra;

    function automatic t_out mk_res(logic [15:0] from, logic [15:0] to, logic is_summ,
                                    logic [15:0] total, t_err err);
        t_out r;
        r.link_from       = from;
        r.link_to         = to;
        r.is_summary      = is_summ;
        r.container_total = total;
        r.error_code      = err;
        r.end_of_run      = 1'b0;
        return r;
    endfunction

    // Take a new character only when the buffer is empty or empties this cycle
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_in_stall  = !i_rst_n ||
                         !((r_res_cnt == 2'd0) || ((r_res_cnt == 2'd1) && !i_out_stall));
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_res_cnt != 2'd0);
    assign o_out_data  = r_res[0];

    assign p = r_pos[IDX_W-1:0];

    // Next state and results for the character at the input
    always_comb begin
        n_pos      = r_pos;
        n_in_quote = r_in_quote;
        n_qstart   = r_qstart;
        n_top      = r_top;
        n_count    = r_count;
        n_cont     = r_cont;
        proc0      = '0;
        proc1      = '0;
        proc_cnt   = 2'd0;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = r_top;

        if (r_pos == POS_W'(MAX_LEN)) begin
            // String too long: drop the character, hold the position
            proc0    = mk_res(16'd0, 16'd0, 1'b0, 16'd0, ERR_TOO_LONG);
            proc_cnt = 2'd1;
        end else begin
            n_pos = r_pos + 1'b1;
            priority if (r_in_quote) begin
                if (i_in_data.ch == CH_QUOTE) begin
                    proc0      = mk_res(16'(r_qstart), 16'(p), 1'b0, 16'd0, ERR_NONE);
                    proc1      = mk_res(16'(p), 16'(r_qstart), 1'b0, 16'd0, ERR_NONE);
                    proc_cnt   = 2'd2;
                    n_in_quote = 1'b0;
                end
            end else if (i_in_data.ch == CH_D || i_in_data.ch == CH_L ||
                         i_in_data.ch == CH_DOLLAR) begin
                if (r_cont != 16'hFFFF) begin
                    n_cont = r_cont + 16'd1;
                end
            end else if (i_in_data.ch == CH_OPEN) begin
                if (r_count == CNT_W'(STACK_DEPTH)) begin
                    proc0    = mk_res(16'd0, 16'd0, 1'b0, 16'd0, ERR_OVERFLOW);
                    proc_cnt = 2'd1;
                end else begin
                    // Spill the old top into the memory, new group on top
                    if (r_count != '0) begin
                        mem_we = 1'b1;
                        mem_wa = MA_W'(r_count - 1'b1);
                    end
                    n_top   = p;
                    n_count = r_count + 1'b1;
                end
            end else if (i_in_data.ch == CH_COMMA || i_in_data.ch == CH_CLOSE) begin
                if (r_count == '0) begin
                    proc0    = mk_res(16'd0, 16'd0, 1'b0, 16'd0, ERR_UNDERFLOW);
                    proc_cnt = 2'd1;
                end else begin
                    proc0    = mk_res(16'(r_top), 16'(p), 1'b0, 16'd0, ERR_NONE);
                    proc_cnt = 2'd1;
                    if (i_in_data.ch == CH_COMMA) begin
                        n_top = p;
                    end else begin
                        n_top   = r_below;
                        n_count = r_count - 1'b1;
                    end
                end
            end else if (i_in_data.ch == CH_QUOTE) begin
                n_in_quote = 1'b1;
                n_qstart   = p;
            end else begin
                // Plain character: only advance the position
            end
        end

        summ = mk_res(16'd0, 16'd0, 1'b1, n_cont, n_in_quote ? ERR_QUOTE : ERR_NONE);

        // Last character: start over for the next string
        if (i_in_data.last) begin
            n_pos      = '0;
            n_in_quote = 1'b0;
            n_qstart   = '0;
            n_count    = '0;
            n_cont     = 16'd0;
        end

        slot[0] = (proc_cnt != 2'd0) ? proc0 : summ;
        slot[1] = (proc_cnt == 2'd2) ? proc1 : summ;
        slot[2] = summ;
        n_res   = proc_cnt + {1'b0, i_in_data.last};
        for (int i = 0; i < 3; i++) begin
            slot[i].end_of_run = (2'(i) == (n_res - 2'd1));
        end

        eff_count = in_acc ? n_count : r_count;
        mem_ra    = MA_W'(eff_count - CNT_W'(2));
    end

    // Scanner state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_in_quote <= 1'b0;
            r_qstart   <= '0;
            r_count    <= '0;
            r_cont     <= 16'd0;
        end else if (in_acc) begin
            r_pos      <= n_pos;
            r_in_quote <= n_in_quote;
            r_qstart   <= n_qstart;
            r_count    <= n_count;
            r_cont     <= n_cont;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_top <= n_top;
        end
    end

    // Stack memory: one write, one registered read of the entry below the top.
    // Forward the write when it lands on the read address.
    always_ff @(posedge i_clk) begin
        if (in_acc && mem_we) begin
            r_stack_mem[mem_wa] <= mem_wd;
        end
        if (in_acc && mem_we && (mem_wa == mem_ra)) begin
            r_below <= mem_wd;
        end else begin
            r_below <= r_stack_mem[mem_ra];
        end
    end

    // Result buffer: load all slots on accept, else shift on each transaction out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_cnt <= 2'd0;
        end else if (in_acc) begin
            r_res_cnt <= n_res;
        end else if (out_acc) begin
            r_res_cnt <= r_res_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res[0] <= slot[0];
            r_res[1] <= slot[1];
            r_res[2] <= slot[2];
        end else if (out_acc) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    // Checks
    `NSLS_ASSERT_NOW(a_stack_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(STACK_DEPTH))
    `NSLS_ASSERT_NOW(a_pos_bound, i_clk, i_rst_n, 1'b1, r_pos <= POS_W'(MAX_LEN))
    `NSLS_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, in_acc && i_in_data.last,
        (r_pos == '0) && (r_count == '0) && !r_in_quote && (r_cont == 16'd0))
    `NSLS_ASSERT_NOW(a_end_marks_final, i_clk, i_rst_n, o_out_valid,
        o_out_data.end_of_run == (r_res_cnt == 2'd1))

endmodule
